@@ rtl/core/mld_pkg.sv @@
// Package for the multi-word long divider: sizes, state codes and shared types.
// Used by mld_store and the top level under rtl/core; depends on nothing.
package mld_pkg;

    localparam int WORDS = 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int KW    = AW + 1;
    localparam int BW    = AW + 5;
    localparam int WBITS = 32;

    localparam logic [1:0] OP_LOAD_DVD = 2'd0;
    localparam logic [1:0] OP_LOAD_DSR = 2'd1;
    localparam logic [1:0] OP_DIVIDE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZCHK,
        ST_STEP,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic             en;
        logic             sel_dsr;
        logic [AW-1:0]    idx;
        logic [WBITS-1:0] val;
    } t_ld_req;

    // Next remainder bank in rotation over three banks.
    function automatic logic [1:0] bank_inc(input logic [1:0] b);
        logic [1:0] r;
        case (b)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/mld_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package needed.
module mld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/mld_store.sv @@
// Operand stores: dividend and divisor RAMs with per-word valid bits so that
// words never loaded since reset read as zero. Depends on mld_pkg and mld_ram.
module mld_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mld_pkg::t_ld_req       i_ld,
    input  logic [mld_pkg::AW-1:0] i_dvd_raddr,
    input  logic [mld_pkg::AW-1:0] i_dsr_raddr,
    output logic [31:0]            o_dvd_rdata,
    output logic [31:0]            o_dsr_rdata
);
    import mld_pkg::*;

    logic [WORDS-1:0] r_dvd_vld;
    logic [WORDS-1:0] r_dsr_vld;
    logic             r_dvd_rv;
    logic             r_dsr_rv;
    logic [31:0]      dvd_raw;
    logic [31:0]      dsr_raw;

    mld_ram #(.WIDTH(32), .DEPTH(WORDS)) u_dvd (
        .i_clk   (i_clk),
        .i_we    (i_ld.en && !i_ld.sel_dsr),
        .i_waddr (i_ld.idx),
        .i_wdata (i_ld.val),
        .i_raddr (i_dvd_raddr),
        .o_rdata (dvd_raw)
    );

    mld_ram #(.WIDTH(32), .DEPTH(WORDS)) u_dsr (
        .i_clk   (i_clk),
        .i_we    (i_ld.en && i_ld.sel_dsr),
        .i_waddr (i_ld.idx),
        .i_wdata (i_ld.val),
        .i_raddr (i_dsr_raddr),
        .o_rdata (dsr_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvd_vld <= '0;
            r_dsr_vld <= '0;
            r_dvd_rv  <= 1'b0;
            r_dsr_rv  <= 1'b0;
        end else begin
            if (i_ld.en && !i_ld.sel_dsr) begin
                r_dvd_vld[i_ld.idx] <= 1'b1;
            end
            if (i_ld.en && i_ld.sel_dsr) begin
                r_dsr_vld[i_ld.idx] <= 1'b1;
            end
            r_dvd_rv <= r_dvd_vld[i_dvd_raddr];
            r_dsr_rv <= r_dsr_vld[i_dsr_raddr];
        end
    end

    assign o_dvd_rdata = r_dvd_rv ? dvd_raw : 32'd0;
    assign o_dsr_rdata = r_dsr_rv ? dsr_raw : 32'd0;
endmodule

@@ rtl/core/multiword_long_divider_core.sv @@
// Top level of the multi-word long divider: control sequencer and word-serial
// restoring-division datapath. Depends on mld_pkg, mld_ram and mld_store.
//
//   channel   | direction | tdata / tuser / tlast
//   s_axis    | in        | tdata: operation[1:0], word_index[6:2], word_value[38:7]
//   m_axis    | out       | tdata: out_index[4:0], quotient[36:5], remainder[68:37];
//             |           | tuser: divide_error; tlast: last word
//
// A divide item first scans the divisor and, if it is nonzero, runs WORDS*32 bit
// steps, each reading every word through the single read port of the remainder
// bank memories. Result words then go out one at a time, each held through any
// output stall. Reset is synchronous and clears control and the operand valid
// bits. Input is accepted only while no division or output is in progress.
module multiword_long_divider_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // operation, word_index, word_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // out_index, quotient_word, remainder_word
    output logic        o_m_axis_tlast,   // last_word
    output logic        o_m_axis_tuser    // divide_error
);
    import mld_pkg::*;

    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic          r_rd_v, n_rd_v;
    logic [AW-1:0] r_rd_k, n_rd_k;
    logic [BW-1:0] r_bit, n_bit;
    logic [1:0]    r_cur, n_cur;
    logic          r_carry, n_carry;
    logic          r_borrow, n_borrow;
    logic [31:0]   r_qword, n_qword;
    logic          r_nz, n_nz;
    logic          r_err, n_err;
    logic [4:0]    r_o_idx, n_o_idx;
    logic [31:0]   r_o_q, n_o_q;
    logic [31:0]   r_o_r, n_o_r;
    logic          r_o_last, n_o_last;
    logic          r_o_vld, n_o_vld;

    logic [1:0]    op;
    logic [4:0]    in_idx;
    logic [31:0]   in_val;
    logic          in_acc;
    t_ld_req       ld;

    logic [AW-1:0] addr_k;
    logic [AW-1:0] dvd_raddr;
    logic [31:0]   dvd_rdata;
    logic [31:0]   dsr_rdata;
    logic [31:0]   rem_rdata [3];
    logic [31:0]   rem_cur;
    logic [1:0]    bank_s;
    logic [1:0]    bank_t;
    logic [2:0]    rem_we;
    logic [31:0]   rem_wdata [3];
    logic          q_we;
    logic [31:0]   q_wdata;
    logic [31:0]   q_rdata;

    logic          issue;
    logic          cin;
    logic          bin;
    logic [31:0]   shifted;
    logic [32:0]   diff;
    logic          ge;
    logic          rd_last;

    assign op     = i_s_axis_tdata[1:0];
    assign in_idx = i_s_axis_tdata[6:2];
    assign in_val = i_s_axis_tdata[38:7];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign ld.en      = in_acc && (op == OP_LOAD_DVD || op == OP_LOAD_DSR)
                        && (int'(in_idx) < WORDS);
    assign ld.sel_dsr = (op == OP_LOAD_DSR);
    assign ld.idx     = AW'(in_idx);
    assign ld.val     = in_val;

    assign addr_k    = r_k[AW-1:0];
    assign dvd_raddr = (r_state == ST_STEP) ? AW'(r_bit[BW-1:5]) : addr_k;

    mld_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ld        (ld),
        .i_dvd_raddr (dvd_raddr),
        .i_dsr_raddr (addr_k),
        .o_dvd_rdata (dvd_rdata),
        .o_dsr_rdata (dsr_rdata)
    );

    // Three remainder banks: one is read each step while the shifted value and
    // the trial difference go to the other two; the winner becomes current.
    for (genvar b = 0; b < 3; b++) begin : g_rem
        mld_ram #(.WIDTH(32), .DEPTH(WORDS)) u_rem (
            .i_clk   (i_clk),
            .i_we    (rem_we[b]),
            .i_waddr (r_state == ST_ZCHK ? addr_k : r_rd_k),
            .i_wdata (rem_wdata[b]),
            .i_raddr (addr_k),
            .o_rdata (rem_rdata[b])
        );
    end

    mld_ram #(.WIDTH(32), .DEPTH(WORDS)) u_quo (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (AW'(r_bit[BW-1:5])),
        .i_wdata (q_wdata),
        .i_raddr (addr_k),
        .o_rdata (q_rdata)
    );

    assign bank_s  = bank_inc(r_cur);
    assign bank_t  = bank_inc(bank_s);
    assign rem_cur = (r_cur == 2'd0) ? rem_rdata[0] :
                     (r_cur == 2'd1) ? rem_rdata[1] : rem_rdata[2];

    assign issue   = (int'(r_k) < WORDS);
    assign rd_last = (int'(r_rd_k) == WORDS - 1);
    assign cin     = (r_rd_k == '0) ? dvd_rdata[r_bit[4:0]] : r_carry;
    assign bin     = (r_rd_k == '0) ? 1'b0 : r_borrow;
    assign shifted = {rem_cur[30:0], cin};
    assign diff    = {1'b0, shifted} - {1'b0, dsr_rdata} - {32'd0, bin};
    assign ge      = rem_cur[31] || !diff[32];
    assign q_wdata = {r_qword[30:0], ge};
    assign q_we    = (r_state == ST_STEP) && r_rd_v && rd_last && (r_bit[4:0] == 5'd0);

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            rem_we[b]    = 1'b0;
            rem_wdata[b] = 32'd0;
            if (r_state == ST_ZCHK) begin
                rem_we[b] = (b == 0) && issue;
            end else if (r_state == ST_STEP && r_rd_v) begin
                if (2'(b) == bank_s) begin
                    rem_we[b]    = 1'b1;
                    rem_wdata[b] = shifted;
                end else if (2'(b) == bank_t) begin
                    rem_we[b]    = 1'b1;
                    rem_wdata[b] = diff[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_rd_v  <= 1'b0;
            r_o_vld <= 1'b0;
            r_err   <= 1'b0;
            r_cur   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_rd_v  <= n_rd_v;
            r_o_vld <= n_o_vld;
            r_err   <= n_err;
            r_cur   <= n_cur;
        end
        r_rd_k   <= n_rd_k;
        r_bit    <= n_bit;
        r_carry  <= n_carry;
        r_borrow <= n_borrow;
        r_qword  <= n_qword;
        r_nz     <= n_nz;
        r_o_idx  <= n_o_idx;
        r_o_q    <= n_o_q;
        r_o_r    <= n_o_r;
        r_o_last <= n_o_last;
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_rd_v   = 1'b0;
        n_rd_k   = addr_k;
        n_bit    = r_bit;
        n_cur    = r_cur;
        n_carry  = r_carry;
        n_borrow = r_borrow;
        n_qword  = r_qword;
        n_nz     = r_nz;
        n_err    = r_err;
        n_o_idx  = r_o_idx;
        n_o_q    = r_o_q;
        n_o_r    = r_o_r;
        n_o_last = r_o_last;
        n_o_vld  = r_o_vld;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && op == OP_DIVIDE) begin
                    n_state = ST_ZCHK;
                    n_k     = '0;
                    n_nz    = 1'b0;
                end
            end
            ST_ZCHK: begin
                if (issue) begin
                    n_rd_v = 1'b1;
                    n_k    = r_k + KW'(1);
                end
                if (r_rd_v) begin
                    n_nz = r_nz || (dsr_rdata != 32'd0);
                    if (rd_last) begin
                        n_k = '0;
                        if (r_nz || (dsr_rdata != 32'd0)) begin
                            n_err   = 1'b0;
                            n_cur   = 2'd0;
                            n_bit   = BW'(WORDS * 32 - 1);
                            n_state = ST_STEP;
                        end else begin
                            n_err   = 1'b1;
                            n_state = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_STEP: begin
                if (issue) begin
                    n_rd_v = 1'b1;
                    n_k    = r_k + KW'(1);
                end
                if (r_rd_v) begin
                    n_carry  = rem_cur[31];
                    n_borrow = diff[32];
                    if (rd_last) begin
                        n_k     = '0;
                        n_qword = q_wdata;
                        n_cur   = ge ? bank_t : bank_s;
                        if (r_bit == '0) begin
                            n_state = ST_OUT_RD;
                        end else begin
                            n_bit = r_bit - BW'(1);
                        end
                    end
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                n_o_idx  = 5'(r_k);
                n_o_q    = r_err ? 32'd0 : q_rdata;
                n_o_r    = r_err ? dvd_rdata : rem_cur;
                n_o_last = (int'(r_k) == WORDS - 1);
                n_o_vld  = 1'b1;
                n_state  = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_m_axis_tready) begin
                    n_o_vld = 1'b0;
                    if (r_o_last) begin
                        n_state = ST_IDLE;
                        n_k     = '0;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {3'd0, r_o_r, r_o_q, r_o_idx};
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_err;

    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> r_state == ST_OUT_HOLD)
        else $error("result valid outside output hold");
    a_bank_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur != 2'd3)
        else $error("remainder bank pointer out of range");
    a_err_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_err) |-> r_o_q == 32'd0)
        else $error("quotient not zero on divide error");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last && i_m_axis_tready) |=> r_state == ST_IDLE)
        else $error("block not idle after last result word");
endmodule

@@ tb/tb_multiword_long_divider_core.sv @@
// Self-checking testbench for multiword_long_divider_core: loads operand words, runs
// divisions and checks every result word against a behavioural 1024-bit divider or typed values.
// Depends on mld_pkg and the core RTL only.
module tb_multiword_long_divider_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mld_pkg::*;

    localparam int NBITS = WORDS * 32;

    typedef struct {
        logic [4:0]  idx;
        logic [31:0] quo;
        logic [31:0] rem;
        logic        last;
        logic        err;
    } t_word_exp;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [31:0] val;
        bit          typed;     // word 0 and the error flag are typed in below
        logic [31:0] quo0;
        logic [31:0] rem0;
        logic        err;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;     // operation, word_index, word_value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;          // out_index, quotient_word, remainder_word
    logic        o_m_axis_tlast;          // last_word
    logic        o_m_axis_tuser;          // divide_error

    logic [NBITS-1:0] dividend_val = '0;
    logic [NBITS-1:0] divisor_val  = '0;
    t_word_exp        pending_words[$];
    int               fail_count = 0;
    bit               quiet_tail = 1'b0;
    int               stall_left = 0;

    multiword_long_divider_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Updates the operand images for one accepted item and queues the result words.
    task automatic divide_predict(input t_row r);
        logic [NBITS-1:0] quo;
        logic [NBITS-1:0] rem;
        logic             err;
        t_word_exp        w;
        if (r.op == OP_LOAD_DVD) begin
            dividend_val[r.idx*32 +: 32] = r.val;
        end else if (r.op == OP_LOAD_DSR) begin
            divisor_val[r.idx*32 +: 32] = r.val;
        end else if (r.op == OP_DIVIDE) begin
            err = (divisor_val == '0);
            if (err) begin
                quo = '0;
                rem = dividend_val;
            end else begin
                quo = dividend_val / divisor_val;
                rem = dividend_val % divisor_val;
            end
            for (int k = 0; k < WORDS; k++) begin
                w.idx  = k[4:0];
                w.quo  = quo[k*32 +: 32];
                w.rem  = rem[k*32 +: 32];
                w.last = (k == WORDS - 1);
                w.err  = err;
                if (r.typed && k == 0) begin
                    w.quo = r.quo0;
                    w.rem = r.rem0;
                    w.err = r.err;
                end else if (r.typed) begin
                    w.err = r.err;
                end
                pending_words.push_back(w);
            end
        end
    endtask

    task automatic send_item(input t_row r);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, r.val, r.idx, r.op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        divide_predict(r);
    endtask

    // Result side back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (quiet_tail) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left      <= $urandom_range(1, 15) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_word_exp w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                if (o_m_axis_tdata[4:0] !== w.idx) begin
                    $error("out_index: expected %0d, got %0d", w.idx, o_m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[36:5] !== w.quo) begin
                    $error("quotient_word: expected %h, got %h", w.quo,
                           o_m_axis_tdata[36:5]);
                    fail_count++;
                end
                if (o_m_axis_tdata[68:37] !== w.rem) begin
                    $error("remainder_word: expected %h, got %h", w.rem,
                           o_m_axis_tdata[68:37]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== w.last) begin
                    $error("last_word: expected %0b, got %0b", w.last, o_m_axis_tlast);
                    fail_count++;
                end
                if (o_m_axis_tuser !== w.err) begin
                    $error("divide_error: expected %0b, got %0b", w.err, o_m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Walked in order: zero divisor after reset, ignored code 3, divide by one,
    // dividend below divisor and repeated divisions on kept operands.
    t_row dir_rows[] = '{
        '{OP_DIVIDE,   5'd0,  32'h0,         1, 32'h0,         32'h0,         1'b1},
        '{OP_LOAD_DVD, 5'd0,  32'hFFFF_FFFF, 0, 32'h0,         32'h0,         1'b0},
        '{OP_LOAD_DVD, 5'd31, 32'h8000_0000, 0, 32'h0,         32'h0,         1'b0},
        '{2'd3,        5'd31, 32'h0001_2345, 0, 32'h0,         32'h0,         1'b0},
        '{OP_DIVIDE,   5'd0,  32'h0,         1, 32'h0,         32'hFFFF_FFFF, 1'b1},
        '{OP_LOAD_DSR, 5'd0,  32'h0000_0001, 0, 32'h0,         32'h0,         1'b0},
        '{OP_DIVIDE,   5'd31, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0,         1'b0},
        '{OP_LOAD_DSR, 5'd0,  32'hFFFF_FFFF, 0, 32'h0,         32'h0,         1'b0},
        '{OP_DIVIDE,   5'd0,  32'h0,         0, 32'h0,         32'h0,         1'b0},
        '{OP_LOAD_DSR, 5'd31, 32'hFFFF_FFFF, 0, 32'h0,         32'h0,         1'b0},
        '{OP_DIVIDE,   5'd0,  32'h0,         1, 32'h0,         32'hFFFF_FFFF, 1'b0},
        '{OP_LOAD_DVD, 5'd15, 32'hAAAA_AAAA, 0, 32'h0,         32'h0,         1'b0},
        '{OP_LOAD_DSR, 5'd31, 32'h0,         0, 32'h0,         32'h0,         1'b0},
        '{OP_LOAD_DSR, 5'd0,  32'h0000_0003, 0, 32'h0,         32'h0,         1'b0},
        '{OP_LOAD_DVD, 5'd21, 32'h5555_5555, 0, 32'h0,         32'h0,         1'b0},
        '{2'd3,        5'd10, 32'h0,         0, 32'h0,         32'h0,         1'b0},
        '{OP_DIVIDE,   5'd0,  32'h0,         0, 32'h0,         32'h0,         1'b0}
    };

    initial begin
        t_row r;
        int   sent;
        int   span;
        int   top;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        sent = 0;
        // Groups of random loads, each closed by a divide; the divisor span is
        // kept short at times so that wide quotients appear.
        while (sent < 250) begin
            span = $urandom_range(6, 30);
            top  = $urandom_range(0, 31);
            if (sent > 200) quiet_tail = 1'b1;
            for (int n = 0; n < span; n++) begin
                r       = '{OP_LOAD_DVD, 5'd0, 32'h0, 0, 32'h0, 32'h0, 1'b0};
                r.idx   = $urandom_range(0, 31);
                r.val   = pick_word();
                case ($urandom_range(0, 9))
                    0:       r.op = 2'd3;
                    1, 2, 3: begin
                        r.op = OP_LOAD_DSR;
                        if (r.idx > top) r.val = 32'h0;
                    end
                    default: r.op = OP_LOAD_DVD;
                endcase
                send_item(r);
            end
            r    = '{OP_DIVIDE, 5'd0, 32'h0, 0, 32'h0, 32'h0, 1'b0};
            r.idx = $urandom_range(0, 31);
            r.val = $urandom;
            send_item(r);
            sent += span + 1;
        end
        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multiword_long_divider_core test passed");
        end else begin
            $display("multiword_long_divider_core test failed");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("multiword_long_divider_core test failed");
        $finish;
    end

endmodule
